/* rtl/tsf_pkg.sv */
// Shared types, constants and helper functions for the touch sample filter.
// No dependencies; every other file of the block depends on this package.
package tsf_pkg;

    localparam int COORD_W     = 12;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 4;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;
    localparam int DEAD_ZONE     = 8;
    localparam int SAMPLES_PER_POINT = 10;
    localparam int AVG_SHIFT     = 3;
    localparam int DIV_STEPS     = COORD_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 32;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_MOVE = 2'd1,
        EV_UP   = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        REG_CAL_X_LOW  = 3'd0,
        REG_CAL_X_HIGH = 3'd1,
        REG_CAL_Y_LOW  = 3'd2,
        REG_CAL_Y_HIGH = 3'd3,
        REG_CALIBRATING = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RELEASE,
        S_MAP,
        S_DIV_START,
        S_DIV_WAIT,
        S_EVAL
    } t_back_state;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        logic               is_release;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_job;

    // Push side of the job queue.
    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    // Pop side of the job queue.
    typedef struct packed {
        logic empty;
        t_job job;
    } t_head;

    typedef struct packed {
        logic [COORD_W-1:0] x_low;
        logic [COORD_W-1:0] x_high;
        logic [COORD_W-1:0] y_low;
        logic [COORD_W-1:0] y_high;
        logic               calibrating;
    } t_cal;

    typedef struct packed {
        logic               zero;
        logic [COORD_W-1:0] num;
        logic [COORD_W-1:0] den;
    } t_map_setup;

    // Sets up the linear map of one axis: distance from the low end and span,
    // in whichever direction the calibration runs.
    function automatic t_map_setup map_setup(input logic [COORD_W-1:0] v,
                                             input logic [COORD_W-1:0] lo,
                                             input logic [COORD_W-1:0] hi);
        t_map_setup r;
        r.zero = 1'b0;
        r.num  = '0;
        r.den  = '0;
        if (hi > lo) begin
            r.zero = (v <= lo);
            r.num  = v - lo;
            r.den  = hi - lo;
        end else if (lo > hi) begin
            r.zero = (v >= lo);
            r.num  = lo - v;
            r.den  = lo - hi;
        end else begin
            r.zero = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/tsf_if.sv */
// Valid/ready channel interfaces for sample requests and touch events.
// Depends on tsf_pkg for field widths.
interface tsf_in_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [tsf_pkg::COORD_W-1:0]    raw_x;
    logic [tsf_pkg::COORD_W-1:0]    raw_y;

    modport source (output valid, output opcode, output raw_x, output raw_y, input ready);
    modport sink   (input valid, input opcode, input raw_x, input raw_y, output ready);
endinterface

interface tsf_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     event_kind;
    logic [tsf_pkg::COORD_W-1:0]    point_x;
    logic [tsf_pkg::COORD_W-1:0]    point_y;

    modport source (output valid, output event_kind, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input event_kind, input point_x, input point_y,
                    output ready);
endinterface

/* rtl/tsf_front.sv */
// Front end: accepts requests, keeps the ten-sample window and queues jobs.
// Depends on tsf_pkg and the channel interfaces in tsf_if.sv.
module tsf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tsf_in_if.sink         i_in,
    input  logic           i_queue_full,
    output tsf_pkg::t_push o_push
);
    import tsf_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COORD_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [SUM_W-1:0]   r_sum_x, r_sum_y;

    logic [COORD_W-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic [SUM_W-1:0]   n_sum_x, n_sum_y, trim_x, trim_y;
    logic               accept, is_release, last_sample;

    assign i_in.ready  = !i_queue_full;
    assign accept      = i_in.valid && i_in.ready;
    assign is_release  = (i_in.opcode == OP_RELEASE);
    assign last_sample = (r_count == COUNT_W'(SAMPLES_PER_POINT - 1));

    always_comb begin
        n_min_x = (i_in.raw_x < r_min_x) ? i_in.raw_x : r_min_x;
        n_max_x = (i_in.raw_x > r_max_x) ? i_in.raw_x : r_max_x;
        n_min_y = (i_in.raw_y < r_min_y) ? i_in.raw_y : r_min_y;
        n_max_y = (i_in.raw_y > r_max_y) ? i_in.raw_y : r_max_y;
        n_sum_x = r_sum_x + SUM_W'(i_in.raw_x);
        n_sum_y = r_sum_y + SUM_W'(i_in.raw_y);
        // Drop the extremes of each axis; the eight left average by a shift.
        trim_x  = n_sum_x - SUM_W'(n_min_x) - SUM_W'(n_max_x);
        trim_y  = n_sum_y - SUM_W'(n_min_y) - SUM_W'(n_max_y);
    end

    always_comb begin
        o_push.push           = accept && (is_release || last_sample);
        o_push.job.is_release = is_release;
        o_push.job.x          = trim_x[AVG_SHIFT +: COORD_W];
        o_push.job.y          = trim_y[AVG_SHIFT +: COORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && (is_release || last_sample))) begin
            r_count <= '0;
            r_min_x <= '1;
            r_min_y <= '1;
            r_max_x <= '0;
            r_max_y <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (accept) begin
            r_count <= r_count + 1'b1;
            r_min_x <= n_min_x;
            r_min_y <= n_min_y;
            r_max_x <= n_max_x;
            r_max_y <= n_max_y;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

endmodule

/* rtl/tsf_fifo.sv */
// Two-entry job queue between the front end and the back end.
// Depends on tsf_pkg for the job type.
module tsf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsf_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output tsf_pkg::t_head o_head
);
    import tsf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]     r_fill;
    logic               do_push, do_pop;

    assign o_full       = (r_fill == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_head.empty = (r_fill == '0);
    assign o_head.job   = r_mem[r_rd_ptr];
    assign do_push      = i_push.push && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

/* rtl/tsf_div.sv */
// Restoring divider, one quotient bit per cycle, for the axis scaling.
// Depends on tsf_pkg; the quotient must be known to fit in COORD_W bits.
module tsf_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tsf_pkg::PROD_W-1:0]   i_dividend,
    input  logic [tsf_pkg::COORD_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [tsf_pkg::COORD_W-1:0]  o_quot
);
    import tsf_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [COORD_W-1:0] r_rem, r_low, r_quot, r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic [COORD_W:0]   trial, diff;
    logic               fits;

    assign trial  = {r_rem, r_low[COORD_W-1]};
    assign fits   = (trial >= {1'b0, r_den});
    assign diff   = trial - {1'b0, r_den};
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // The upper half of the dividend is below the divisor, so it seeds the
    // remainder and only the lower half is shifted through.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend[PROD_W-1:COORD_W];
            r_low  <= i_dividend[COORD_W-1:0];
            r_den  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            r_low  <= {r_low[COORD_W-2:0], 1'b0};
            r_quot <= {r_quot[COORD_W-2:0], fits};
        end
    end

endmodule

/* rtl/tsf_back.sv */
// Back end: scales queued points, applies the dead zone and issues events.
// Depends on tsf_pkg, tsf_if.sv and tsf_div.
module tsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsf_pkg::t_head i_head,
    output logic           o_pop,
    input  tsf_pkg::t_cal  i_cal,
    tsf_out_if.source      o_out
);
    import tsf_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;

    logic [PROD_W-1:0]  r_prod_x, r_prod_y;
    logic [COORD_W-1:0] r_den_x, r_den_y;
    logic               r_zero_x, r_zero_y, r_sat_x, r_sat_y;
    logic [COORD_W-1:0] r_cur_x, r_cur_y, r_rep_x, r_rep_y;
    logic               r_pen;
    logic               r_out_valid;
    t_event             r_out_kind;
    logic [COORD_W-1:0] r_out_x, r_out_y;

    t_map_setup         setup_x, setup_y;
    logic               div_start, busy_x, busy_y;
    logic [COORD_W-1:0] quot_x, quot_y, pt_x, pt_y;
    logic               out_free, moved, emit, show;
    t_event             kind;
    logic               load_job, load_map, load_rel, commit;

    assign out_free = !r_out_valid || o_out.ready;

    assign setup_x = map_setup(r_job.x, i_cal.x_low, i_cal.x_high);
    assign setup_y = map_setup(r_job.y, i_cal.y_low, i_cal.y_high);

    tsf_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod_x),
        .i_divisor  (r_den_x),
        .o_busy     (busy_x),
        .o_quot     (quot_x)
    );

    tsf_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod_y),
        .i_divisor  (r_den_y),
        .o_busy     (busy_y),
        .o_quot     (quot_y)
    );

    // Final point: raw average while calibrating, otherwise the scaled value
    // clamped to the screen edges.
    always_comb begin
        if (i_cal.calibrating) begin
            pt_x = r_job.x;
            pt_y = r_job.y;
        end else begin
            pt_x = r_zero_x ? '0 : (r_sat_x ? COORD_W'(SCREEN_WIDTH) : quot_x);
            pt_y = r_zero_y ? '0 : (r_sat_y ? COORD_W'(SCREEN_HEIGHT) : quot_y);
        end
        moved = (abs_diff(pt_x, r_rep_x) >= COORD_W'(DEAD_ZONE)) ||
                (abs_diff(pt_y, r_rep_y) >= COORD_W'(DEAD_ZONE));
        emit  = !r_pen || moved;
        kind  = r_pen ? EV_MOVE : EV_DOWN;
        show  = emit && !i_cal.calibrating;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_job  = 1'b0;
        load_map  = 1'b0;
        load_rel  = 1'b0;
        div_start = 1'b0;
        commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_head.empty) begin
                    o_pop    = 1'b1;
                    load_job = 1'b1;
                    if (i_head.job.is_release) begin
                        n_state = S_RELEASE;
                    end else if (i_cal.calibrating) begin
                        n_state = S_EVAL;
                    end else begin
                        n_state = S_MAP;
                    end
                end
            end
            S_RELEASE: begin
                if (out_free) begin
                    load_rel = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_MAP: begin
                load_map = 1'b1;
                n_state  = S_DIV_START;
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!busy_x && !busy_y) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!show || out_free) begin
                    commit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_job <= i_head.job;
        end
        if (load_map) begin
            r_zero_x <= setup_x.zero;
            r_zero_y <= setup_y.zero;
            r_sat_x  <= setup_x.num >= setup_x.den;
            r_sat_y  <= setup_y.num >= setup_y.den;
            r_den_x  <= setup_x.den;
            r_den_y  <= setup_y.den;
            r_prod_x <= PROD_W'(setup_x.num) * PROD_W'(SCREEN_WIDTH);
            r_prod_y <= PROD_W'(setup_y.num) * PROD_W'(SCREEN_HEIGHT);
        end
    end

    // Pen state and the current and last reported points.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen   <= 1'b0;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_rep_x <= '0;
            r_rep_y <= '0;
        end else if (load_rel) begin
            r_pen <= 1'b0;
        end else if (commit) begin
            r_pen   <= 1'b1;
            r_cur_x <= pt_x;
            r_cur_y <= pt_y;
            if (emit) begin
                r_rep_x <= pt_x;
                r_rep_y <= pt_y;
            end
        end
    end

    // Output register: holds one event until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_rel || (commit && show)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_rel) begin
            r_out_kind <= EV_UP;
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
        end else if (commit && show) begin
            r_out_kind <= kind;
            r_out_x    <= pt_x;
            r_out_y    <= pt_y;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_kind = r_out_kind;
    assign o_out.point_x    = r_out_x;
    assign o_out.point_y    = r_out_y;

endmodule

/* rtl/touch_sample_filter_event.sv */
// Touch sample filter and event generator, top level with the register port.
// Depends on tsf_pkg, tsf_if.sv, tsf_front, tsf_fifo and tsf_back.
//
// The block takes requests on i_sample, each either a pair of 12-bit touch
// converter readings or a pen-release marker, and issues down, move and up
// events on o_event. Ten sample pairs make one point: per axis the largest
// and smallest reading are dropped and the other eight averaged. Unless the
// calibrating register is set, each average is mapped linearly from the
// calibration low and high readings onto 0..240 columns and 0..320 rows,
// clamped at the screen edges; the low reading may be above the high one,
// and equal readings give 0. The first point after a release is a down
// event; later points give a move event only when one axis differs by 8 or
// more from the last reported point. A release always gives an up event
// with the last point and drops any partial window. While calibrating, only
// up events appear and points are raw averages. The front end takes one
// request every cycle as long as its two-entry job queue has room; only
// every tenth sample and each release make a job. The back end takes a
// point through pop, setup and multiply, divider start, the bit-serial
// divider and decision; a release, or a point while calibrating, goes
// from the pop straight to its final step. A finished event waits
// in an output register, so the back end moves on while it is pending. The
// calibration registers sit at byte addresses 0, 4, 8, 12 and 16 and should
// be written only while no request is in flight.
module touch_sample_filter_event (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tsf_in_if.sink                         i_sample,
    tsf_out_if.source                      o_event,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsf_pkg::PADDR_W-1:0]    paddr,
    input  logic [tsf_pkg::PDATA_W-1:0]    pwdata,
    output logic [tsf_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import tsf_pkg::*;

    t_cal     r_cal;
    t_push    push;
    t_head    head;
    logic     queue_full, pop, cfg_write;
    t_reg_idx reg_idx;

    // Registers are word aligned; the two low address bits are ignored.
    assign reg_idx   = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.x_low       <= '0;
            r_cal.x_high      <= '1;
            r_cal.y_low       <= '0;
            r_cal.y_high      <= '1;
            r_cal.calibrating <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_CAL_X_LOW:   r_cal.x_low       <= pwdata[COORD_W-1:0];
                REG_CAL_X_HIGH:  r_cal.x_high      <= pwdata[COORD_W-1:0];
                REG_CAL_Y_LOW:   r_cal.y_low       <= pwdata[COORD_W-1:0];
                REG_CAL_Y_HIGH:  r_cal.y_high      <= pwdata[COORD_W-1:0];
                REG_CALIBRATING: r_cal.calibrating <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAL_X_LOW:   prdata = PDATA_W'(r_cal.x_low);
            REG_CAL_X_HIGH:  prdata = PDATA_W'(r_cal.x_high);
            REG_CAL_Y_LOW:   prdata = PDATA_W'(r_cal.y_low);
            REG_CAL_Y_HIGH:  prdata = PDATA_W'(r_cal.y_high);
            REG_CALIBRATING: prdata = PDATA_W'(r_cal.calibrating);
            default:         prdata = '0;
        endcase
    end

    // Front end: sample window and job classification.
    tsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_sample),
        .i_queue_full (queue_full),
        .o_push       (push)
    );

    // Job queue that lets the two halves stall independently.
    tsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    // Back end: scaling, dead zone and event output.
    tsf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .i_cal   (r_cal),
        .o_out   (o_event)
    );

endmodule

/* dv/touch_sample_filter_event_test.sv */
// Self-checking testbench for the touch sample filter and event generator.
// Depends on tsf_pkg, the channel interfaces in tsf_if.sv and the block's top level.
module touch_sample_filter_event_test;
    import tsf_pkg::*;

    // Room for the back end to finish a point that makes no event, plus the
    // pending output register, before the registers are touched again.
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PERCENT  = 37;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;

    typedef struct {
        t_event             kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_touch_event;

    logic i_clk;
    logic i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tsf_in_if  smp ();
    tsf_out_if evt ();

    touch_sample_filter_event u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp),
        .o_event  (evt),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Events that the block still owes, oldest first.
    t_touch_event pending_events[$];

    // Shadow of the calibration registers.
    logic [COORD_W-1:0] cfg_x_low, cfg_x_high, cfg_y_low, cfg_y_high;
    logic               cfg_calibrating;

    // Shadow of the filter: the current window of samples and the pen state.
    int unsigned        win_count;
    logic [COORD_W-1:0] win_lo_x, win_hi_x, win_lo_y, win_hi_y;
    logic [SUM_W-1:0]   win_sum_x, win_sum_y;
    logic [COORD_W-1:0] last_x, last_y;
    logic [COORD_W-1:0] shown_x, shown_y;
    logic               pen_is_down;

    // When set, neither the sender nor the receiver ever idles.
    bit          steady_flow;
    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned events_checked;
    int unsigned settings_used;
    int unsigned mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost event ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("touch_sample_filter_event_test NOT OK");
        $finish;
    end

    // The event receiver stalls at random, except during the steady phase.
    initial begin
        evt.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            evt.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Every accepted event is compared with the oldest one still owed. The
    // values read right after the edge are those the block presented at it.
    always @(posedge i_clk) begin : check_events
        t_touch_event want;
        if (i_rst_n && evt.valid && evt.ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected event: kind %0d at (%0d, %0d)",
                       evt.event_kind, evt.point_x, evt.point_y);
                mismatch_count++;
            end else begin
                want = pending_events.pop_front();
                events_checked++;
                if (evt.event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, evt.event_kind);
                    mismatch_count++;
                end
                if (evt.point_x !== want.x) begin
                    $error("point_x: expected %0d, got %0d", want.x, evt.point_x);
                    mismatch_count++;
                end
                if (evt.point_y !== want.y) begin
                    $error("point_y: expected %0d, got %0d", want.y, evt.point_y);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void clear_window();
        win_count = 0;
        win_lo_x  = COORD_MAX;
        win_lo_y  = COORD_MAX;
        win_hi_x  = '0;
        win_hi_y  = '0;
        win_sum_x = '0;
        win_sum_y = '0;
    endfunction

    function automatic void reset_prediction();
        cfg_x_low       = '0;
        cfg_x_high      = COORD_MAX;
        cfg_y_low       = '0;
        cfg_y_high      = COORD_MAX;
        cfg_calibrating = 1'b0;
        clear_window();
        last_x      = '0;
        last_y      = '0;
        shown_x     = '0;
        shown_y     = '0;
        pen_is_down = 1'b0;
    endfunction

    // Linear map of one averaged reading onto 0..size. The calibration may
    // run either way; a zero span maps everything to 0, and readings past
    // either end clamp to the screen edge.
    function automatic logic [COORD_W-1:0] scale_axis(input logic [COORD_W-1:0] v,
                                                      input logic [COORD_W-1:0] lo,
                                                      input logic [COORD_W-1:0] hi,
                                                      input int unsigned size);
        int unsigned reach, span, scaled;
        if (hi == lo) return '0;
        if (hi > lo) begin
            if (v <= lo) return '0;
            reach = 32'(v - lo);
            span  = 32'(hi - lo);
        end else begin
            if (v >= lo) return '0;
            reach = 32'(lo - v);
            span  = 32'(lo - hi);
        end
        scaled = (reach * size) / span;
        if (scaled > size) scaled = size;
        return scaled[COORD_W-1:0];
    endfunction

    function automatic int unsigned axis_distance(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    // Advances the shadow filter by one accepted request and queues the
    // event that it must produce, if any.
    function automatic void predict_touch_event(input t_opcode op,
                                                input logic [COORD_W-1:0] rx,
                                                input logic [COORD_W-1:0] ry);
        logic [31:0]        trimmed_x, trimmed_y;
        logic [COORD_W-1:0] ax, ay;
        t_event             kind;
        bit                 report;
        report = 1'b0;
        kind   = EV_DOWN;
        if (op == OP_RELEASE) begin
            // A release always reports the last point, even without a down.
            clear_window();
            pen_is_down = 1'b0;
            pending_events.push_back('{EV_UP, last_x, last_y});
            return;
        end
        if (rx < win_lo_x) win_lo_x = rx;
        if (rx > win_hi_x) win_hi_x = rx;
        if (ry < win_lo_y) win_lo_y = ry;
        if (ry > win_hi_y) win_hi_y = ry;
        win_sum_x = win_sum_x + SUM_W'(rx);
        win_sum_y = win_sum_y + SUM_W'(ry);
        win_count++;
        if (win_count < SAMPLES_PER_POINT) return;

        // Drop the extremes of each axis and average the other eight.
        trimmed_x = 32'(win_sum_x) - 32'(win_lo_x) - 32'(win_hi_x);
        trimmed_y = 32'(win_sum_y) - 32'(win_lo_y) - 32'(win_hi_y);
        ax = trimmed_x[AVG_SHIFT +: COORD_W];
        ay = trimmed_y[AVG_SHIFT +: COORD_W];
        clear_window();
        if (!cfg_calibrating) begin
            ax = scale_axis(ax, cfg_x_low, cfg_x_high, SCREEN_WIDTH);
            ay = scale_axis(ay, cfg_y_low, cfg_y_high, SCREEN_HEIGHT);
        end
        last_x = ax;
        last_y = ay;

        if (!pen_is_down) begin
            pen_is_down = 1'b1;
            report      = 1'b1;
            kind        = EV_DOWN;
        end else if (axis_distance(ax, shown_x) >= DEAD_ZONE ||
                     axis_distance(ay, shown_y) >= DEAD_ZONE) begin
            report = 1'b1;
            kind   = EV_MOVE;
        end
        if (report) begin
            shown_x = ax;
            shown_y = ay;
        end
        // While calibrating the pen state still moves, but only ups are shown.
        if (report && !cfg_calibrating) pending_events.push_back('{kind, ax, ay});
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one request. The sender idles first at random; valid stays high
    // after acceptance so that back-to-back requests follow without a gap.
    task automatic send_request(input t_opcode op, input logic [COORD_W-1:0] rx,
                                input logic [COORD_W-1:0] ry);
        int unsigned gap;
        gap = 0;
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.opcode <= op;
        smp.raw_x  <= rx;
        smp.raw_y  <= ry;
        do @(posedge i_clk); while (!smp.ready);
        requests_sent++;
        predict_touch_event(op, rx, ry);
    endtask

    // Stops sending and waits until every owed event has come, then lets
    // the given number of cycles pass for work that makes no event.
    task automatic wait_until_drained(input int unsigned extra_cycles);
        smp.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    // One register write: a setup phase, then an access phase that completes
    // at the first edge with pready high.
    task automatic write_cal_register(input t_reg_idx idx, input logic [COORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CAL_X_LOW:   cfg_x_low       = value;
            REG_CAL_X_HIGH:  cfg_x_high      = value;
            REG_CAL_Y_LOW:   cfg_y_low       = value;
            REG_CAL_Y_HIGH:  cfg_y_high      = value;
            REG_CALIBRATING: cfg_calibrating = value[0];
            default: ;
        endcase
    endtask

    // Rewrites all five registers once the block has gone quiet.
    task automatic set_calibration(input logic [COORD_W-1:0] x_low,
                                   input logic [COORD_W-1:0] x_high,
                                   input logic [COORD_W-1:0] y_low,
                                   input logic [COORD_W-1:0] y_high,
                                   input logic calibrating);
        wait_until_drained(SETTLE_CYCLES);
        write_cal_register(REG_CAL_X_LOW, x_low);
        write_cal_register(REG_CAL_X_HIGH, x_high);
        write_cal_register(REG_CAL_Y_LOW, y_low);
        write_cal_register(REG_CAL_Y_HIGH, y_high);
        write_cal_register(REG_CALIBRATING, COORD_W'(calibrating));
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Stroke generation
    // ------------------------------------------------------------------

    function automatic logic [COORD_W-1:0] jittered(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] wild_reading();
        case ($urandom_range(2))
            0:       return '0;
            1:       return COORD_MAX;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // A stroke is what a finger does: a few windows of samples around a
    // slowly or quickly drifting point, then a release. A few strokes are
    // cut off partway through a window, and a few samples are wild.
    task automatic send_stroke(input bit pause_after);
        int cx, cy, windows, spread, cut;
        if ($urandom_range(99) < 5) send_request(OP_RELEASE, wild_reading(), wild_reading());
        cx      = $urandom_range(4095);
        cy      = $urandom_range(4095);
        windows = $urandom_range(1, 4);
        for (int w = 0; w < windows; w++) begin
            spread = $urandom_range(0, 24);
            cut    = ($urandom_range(99) < 6) ? $urandom_range(1, 9) : SAMPLES_PER_POINT;
            for (int s = 0; s < cut; s++) begin
                if ($urandom_range(99) < 3)
                    send_request(OP_SAMPLE, wild_reading(), wild_reading());
                else
                    send_request(OP_SAMPLE, jittered(cx, spread), jittered(cy, spread));
            end
            if (cut != SAMPLES_PER_POINT) break;
            // Small drifts mostly stay inside the dead zone, large ones move.
            if ($urandom_range(1) == 1) begin
                cx = int'(jittered(cx, 4));
                cy = int'(jittered(cy, 4));
            end else begin
                cx = int'(jittered(cx, 300));
                cy = int'(jittered(cy, 300));
            end
        end
        send_request(OP_RELEASE, COORD_W'($urandom), COORD_W'($urandom));
        if (pause_after) wait_until_drained(0);
    endtask

    task automatic run_strokes(input int unsigned count, input bit pause_after);
        int unsigned target;
        target = requests_sent + count;
        while (requests_sent < target) send_stroke(pause_after);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // An up event before any down carries the reset point.
    task automatic test_release_without_touch();
        send_request(OP_RELEASE, COORD_MAX, '0);
    endtask

    // One window with both converter extremes on each axis, so that the
    // trimming drops exactly those; the result is a down event.
    task automatic test_window_extremes();
        logic [COORD_W-1:0] x, y;
        for (int i = 0; i < SAMPLES_PER_POINT; i++) begin
            x = (i == 0) ? '0 : (i == 1) ? COORD_MAX : COORD_W'(1000 + 13 * i);
            y = (i == 0) ? COORD_MAX : (i == 1) ? '0 : COORD_W'(2000 - 7 * i);
            send_request(OP_SAMPLE, x, y);
        end
    endtask

    // x calibrated in reverse with readings beyond the high end, so it
    // saturates to the screen width; y has equal ends and maps to 0. The
    // pen is still down from the previous window, so this is a move, and
    // the release then reports that point.
    task automatic test_reversed_and_equal_calibration();
        set_calibration(12'd3000, 12'd1000, 12'd2000, 12'd2000, 1'b0);
        for (int i = 0; i < SAMPLES_PER_POINT; i++)
            send_request(OP_SAMPLE, jittered(500, 40), COORD_W'($urandom));
        send_request(OP_RELEASE, '0, COORD_MAX);
    endtask

    task automatic test_default_calibration();
        set_calibration('0, COORD_MAX, '0, COORD_MAX, 1'b0);
        run_strokes(180, 1'b0);
    endtask

    // Calibration ends at the edges of the converter range and one apart.
    task automatic test_extreme_calibration();
        set_calibration(COORD_MAX, '0, '0, 12'd1, 1'b0);
        run_strokes(90, 1'b0);
        set_calibration(12'd4094, COORD_MAX, COORD_MAX, 12'd4094, 1'b0);
        run_strokes(90, 1'b0);
    endtask

    task automatic test_random_calibration();
        repeat (3) begin
            set_calibration(COORD_W'($urandom), COORD_W'($urandom),
                            COORD_W'($urandom), COORD_W'($urandom), 1'b0);
            run_strokes(60, 1'b0);
        end
    endtask

    // Narrow spans in the middle: most averages clamp at one edge or the other.
    task automatic test_narrow_calibration();
        set_calibration(12'd1800, 12'd2200, 12'd2300, 12'd1700, 1'b0);
        run_strokes(180, 1'b0);
    endtask

    task automatic test_equal_calibration();
        logic [COORD_W-1:0] ends;
        ends = COORD_W'($urandom);
        set_calibration(ends, ends, COORD_W'($urandom), COORD_W'($urandom), 1'b0);
        run_strokes(150, 1'b0);
    endtask

    // Raw averages and up events only; the pen state still tracks downs.
    task automatic test_calibrating_mode();
        set_calibration(COORD_W'($urandom), COORD_W'($urandom),
                        COORD_W'($urandom), COORD_W'($urandom), 1'b1);
        run_strokes(180, 1'b0);
    endtask

    // A long stretch at full rate on both sides.
    task automatic test_steady_flow();
        set_calibration(12'd200, 12'd3900, 12'd3900, 12'd200, 1'b0);
        steady_flow = 1'b1;
        run_strokes(250, 1'b0);
        steady_flow = 1'b0;
    endtask

    // The sender stops after each stroke until every owed event has come.
    task automatic test_drained_pauses();
        set_calibration('0, COORD_MAX, '0, COORD_MAX, 1'b0);
        run_strokes(150, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        steady_flow    = 1'b0;
        requests_sent  = 0;
        events_checked = 0;
        settings_used  = 0;
        mismatch_count = 0;
        reset_prediction();
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        smp.valid  <= 1'b0;
        smp.opcode <= OP_SAMPLE;
        smp.raw_x  <= '0;
        smp.raw_y  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_release_without_touch();
        test_window_extremes();
        test_reversed_and_equal_calibration();
        test_default_calibration();
        test_extreme_calibration();
        test_random_calibration();
        test_narrow_calibration();
        test_equal_calibration();
        test_calibrating_mode();
        test_steady_flow();
        test_drained_pauses();

        wait_until_drained(SETTLE_CYCLES);
        $display("Sent %0d sample and release requests over %0d calibration settings.",
                 requests_sent, settings_used);
        $display("Checked %0d touch events; %0d mismatches.", events_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("touch_sample_filter_event_test OK");
        end else begin
            $display("touch_sample_filter_event_test NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tsf_pkg.sv
rtl/tsf_if.sv
rtl/tsf_front.sv
rtl/tsf_fifo.sv
rtl/tsf_div.sv
rtl/tsf_back.sv
rtl/touch_sample_filter_event.sv
dv/touch_sample_filter_event_test.sv
